### rtl/icmp_reply_classifier_assert.svh
// Assertion macros for the ICMP reply classifier RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ICMP_REPLY_CLASSIFIER_ASSERT_SVH
`define ICMP_REPLY_CLASSIFIER_ASSERT_SVH

`ifndef ASSERT_OFF

// Expression must hold at every clock edge out of reset
`define ICR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("icr assertion failed");

// Antecedent at one edge implies consequent at the next edge
`define ICR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("icr assertion failed");

`else

`define ICR_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ICR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/icr_pkg.sv
package icr_pkg;

	// Packet geometry
	localparam int MAX_PACKET_BYTES = 2048;
	localparam int OFF_W            = $clog2(MAX_PACKET_BYTES);
	localparam int OFF_LAST         = MAX_PACKET_BYTES - 1;
	localparam int RECV_LIMIT       = 1500;
	localparam int LIMIT_W          = $clog2(RECV_LIMIT + 1);
	// Received length (offset + 1) and the offset compare width
	localparam int LEN_W            = (OFF_W + 1 > LIMIT_W) ? OFF_W + 1 : LIMIT_W;
	localparam int CMP_W            = (OFF_W > 8) ? OFF_W : 8;

	// Protocol codes
	localparam logic [7:0] PROTO_ICMP         = 8'd1;
	localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
	localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

	// Configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_IDENTIFIER    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SEQUENCE = 8'd1;

	typedef enum logic [1:0] {
		VERDICT_IGNORED       = 2'd0,
		VERDICT_ECHO_REPLY    = 2'd1,
		VERDICT_TIME_EXCEEDED = 2'd2
	} verdict_t;

	// Per-packet parse state
	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic [5:0]       hdr_len;
		logic             outer_icmp;
		logic [7:0]       msg_type;
		logic [15:0]      outer_ident;
		logic [15:0]      outer_seq;
		logic             inner_icmp;
		logic [5:0]       inner_hdr_len;
		logic [15:0]      inner_ident;
		logic [15:0]      inner_seq;
		logic [31:0]      src;
	} fields_t;

endpackage

### rtl/icr_field_tracker.sv
// Walks the packet byte offsets and captures header and ICMP fields.
// cur shows the fields with the current byte already applied.
module icr_field_tracker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [7:0]        packet_byte,
	input  logic              last_byte,
	output icr_pkg::fields_t  cur
);

	icr_pkg::fields_t            fields_q;
	icr_pkg::fields_t            nx;
	icr_pkg::fields_t            adv_c;
	logic [icr_pkg::CMP_W-1:0]   off_c;
	logic [icr_pkg::CMP_W-1:0]   hl_c;
	logic [icr_pkg::CMP_W-1:0]   p_c;
	logic [icr_pkg::CMP_W-1:0]   q_c;
	logic [icr_pkg::OFF_W-1:0]   off_next;

	// Apply the current byte to whatever field sits at its offset
	always_comb begin
		nx    = fields_q;
		off_c = icr_pkg::CMP_W'(fields_q.offset);

		if (fields_q.offset == '0) begin
			nx.hdr_len = {packet_byte[3:0], 2'b00};
		end
		hl_c = icr_pkg::CMP_W'(nx.hdr_len);
		p_c  = hl_c + icr_pkg::CMP_W'(8);
		// inner length only changes at p, and q is used only past p
		q_c  = p_c + icr_pkg::CMP_W'(fields_q.inner_hdr_len);

		if (off_c == icr_pkg::CMP_W'(9)) begin
			nx.outer_icmp = (packet_byte == icr_pkg::PROTO_ICMP);
		end
		if (off_c >= icr_pkg::CMP_W'(12) && off_c <= icr_pkg::CMP_W'(15)) begin
			unique case (off_c[1:0])
				2'd0: nx.src[31:24] = packet_byte;
				2'd1: nx.src[23:16] = packet_byte;
				2'd2: nx.src[15:8]  = packet_byte;
				2'd3: nx.src[7:0]   = packet_byte;
				default: nx.src = fields_q.src;
			endcase
		end

		// Outer ICMP header
		if (off_c == hl_c) nx.msg_type = packet_byte;
		if (off_c == hl_c + icr_pkg::CMP_W'(4)) nx.outer_ident[7:0]  = packet_byte;
		if (off_c == hl_c + icr_pkg::CMP_W'(5)) nx.outer_ident[15:8] = packet_byte;
		if (off_c == hl_c + icr_pkg::CMP_W'(6)) nx.outer_seq[7:0]    = packet_byte;
		if (off_c == hl_c + icr_pkg::CMP_W'(7)) nx.outer_seq[15:8]   = packet_byte;

		// Quoted inner IP header and its ICMP header
		if (off_c == p_c) nx.inner_hdr_len = {packet_byte[3:0], 2'b00};
		if (off_c == p_c + icr_pkg::CMP_W'(9)) begin
			nx.inner_icmp = (packet_byte == icr_pkg::PROTO_ICMP);
		end
		if (off_c > p_c) begin
			if (off_c == q_c + icr_pkg::CMP_W'(4)) nx.inner_ident[7:0]  = packet_byte;
			if (off_c == q_c + icr_pkg::CMP_W'(5)) nx.inner_ident[15:8] = packet_byte;
			if (off_c == q_c + icr_pkg::CMP_W'(6)) nx.inner_seq[7:0]    = packet_byte;
			if (off_c == q_c + icr_pkg::CMP_W'(7)) nx.inner_seq[15:8]   = packet_byte;
		end
	end

	// Offset stops at the last slot of the largest packet
	assign off_next = (fields_q.offset == icr_pkg::OFF_W'(icr_pkg::OFF_LAST)) ?
		fields_q.offset : fields_q.offset + icr_pkg::OFF_W'(1);

	// Next register contents: applied fields with the offset stepped
	always_comb begin
		adv_c        = nx;
		adv_c.offset = off_next;
	end

	// State register, cleared after each final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fields_q <= '0;
		end else if (advance) begin
			if (last_byte) begin
				fields_q <= '0;
			end else begin
				fields_q <= adv_c;
			end
		end
	end

	assign cur = nx;

endmodule

### rtl/icr_matcher.sv
// Final-byte classification from the parsed fields and the probe registers.
module icr_matcher (
	input  icr_pkg::fields_t  cur,
	input  logic [15:0]       own_identifier,
	input  logic [15:0]       expected_sequence,
	output icr_pkg::verdict_t verdict
);

	logic [icr_pkg::LEN_W-1:0] len_raw;
	logic [icr_pkg::LEN_W-1:0] len_c;
	logic [icr_pkg::LEN_W-1:0] need_outer;
	logic [icr_pkg::LEN_W-1:0] need_inner;

	// Received length, clipped at the receive buffer size
	assign len_raw = icr_pkg::LEN_W'(cur.offset) + icr_pkg::LEN_W'(1);
	assign len_c   = (len_raw > icr_pkg::LEN_W'(icr_pkg::RECV_LIMIT)) ?
		icr_pkg::LEN_W'(icr_pkg::RECV_LIMIT) : len_raw;

	assign need_outer = icr_pkg::LEN_W'(cur.hdr_len) + icr_pkg::LEN_W'(8);
	assign need_inner = icr_pkg::LEN_W'(cur.hdr_len) + icr_pkg::LEN_W'(16) +
		icr_pkg::LEN_W'(cur.inner_hdr_len);

	// Echo reply wins over time exceeded
	always_comb begin
		verdict = icr_pkg::VERDICT_IGNORED;
		if (cur.outer_icmp && len_c >= need_outer) begin
			priority if (cur.msg_type == icr_pkg::TYPE_ECHO_REPLY &&
				cur.outer_seq == expected_sequence &&
				cur.outer_ident == own_identifier) begin
				verdict = icr_pkg::VERDICT_ECHO_REPLY;
			end else if (cur.msg_type == icr_pkg::TYPE_TIME_EXCEEDED &&
				cur.inner_icmp && len_c >= need_inner &&
				cur.inner_seq == expected_sequence &&
				cur.inner_ident == own_identifier) begin
				verdict = icr_pkg::VERDICT_TIME_EXCEEDED;
			end else begin
				verdict = icr_pkg::VERDICT_IGNORED;
			end
		end
	end

endmodule

### rtl/icmp_reply_classifier.sv
// ICMP reply classifier: takes a received IPv4 packet one byte per cycle, last byte marked,
// and gives one result per packet: a verdict (ignored, matching echo reply, matching time
// exceeded) and the outer source address. Bytes are taken every cycle back to back; a byte
// passes an input register, then the field tracker and matcher, and the result sits in an
// output register. Only a final byte waits on a result still stalled at the output.
// own_identifier and expected_sequence are written over the cfg port (always ready) and
// are compared low byte first as on the wire; write them only between packets.
`include "icmp_reply_classifier_assert.svh"

module icmp_reply_classifier (
	input  logic                           clk,
	input  logic                           arst_n,
	// Packet byte channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     packet_byte,
	input  logic                           last_byte,
	// Result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     verdict,
	output logic [31:0]                    source_address,
	// Configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [icr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              advance;
	logic [15:0]       own_ident_q;
	logic [15:0]       exp_seq_q;
	logic              out_valid_q;
	icr_pkg::verdict_t verdict_q;
	logic [31:0]       source_q;
	icr_pkg::fields_t  cur;
	icr_pkg::verdict_t verdict_c;

	// Only a final byte can be held back, by a stalled result
	assign in_stall = valid_s1 && last_s1 && out_valid_q && out_stall;
	assign advance  = valid_s1 && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= packet_byte;
			last_s1 <= last_byte;
		end
	end

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ident_q <= 16'd0;
			exp_seq_q   <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == icr_pkg::REG_OWN_IDENTIFIER) own_ident_q <= cfg_data;
			if (cfg_index == icr_pkg::REG_EXPECTED_SEQUENCE) exp_seq_q <= cfg_data;
		end
	end

	icr_field_tracker u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.packet_byte (byte_s1),
		.last_byte   (last_s1),
		.cur         (cur)
	);

	icr_matcher u_matcher (
		.cur               (cur),
		.own_identifier    (own_ident_q),
		.expected_sequence (exp_seq_q),
		.verdict           (verdict_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			verdict_q <= verdict_c;
			source_q  <= cur.src;
		end
	end

	assign out_valid      = out_valid_q;
	assign verdict        = verdict_q;
	assign source_address = source_q;

	// A final byte always yields a result in the next cycle
	`ICR_ASSERT_NEXT(a_last_gives_result, clk, arst_n, advance && last_s1, out_valid_q)
	// A non-final byte never creates a result
	`ICR_ASSERT_NEXT(a_no_spurious_result, clk, arst_n,
		advance && !last_s1 && !(out_valid_q && out_stall), !out_valid_q)
	// Back-pressure only ever holds a final byte behind a stalled result
	`ICR_ASSERT_ALWAYS(a_stall_reason, clk, arst_n,
		!in_stall || (valid_s1 && last_s1 && out_valid_q))
	// A verdict code never leaves the defined set
	`ICR_ASSERT_ALWAYS(a_verdict_code, clk, arst_n,
		!out_valid_q || verdict_q != 2'd3)

endmodule

### verif/icmp_reply_classifier_test.sv
module icmp_reply_classifier_test;

	localparam logic [7:0] PROTO_TCP        = 8'd6;
	localparam logic [7:0] PROTO_UDP        = 8'd17;
	localparam logic [7:0] TYPE_UNREACHABLE = 8'd3;
	localparam int         HOLD_CYCLES      = 300;
	localparam int         SETTLE_CYCLES    = 8;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} wire_byte_t;

	typedef struct {
		icr_pkg::verdict_t verdict;
		logic [31:0]       source;
	} classification_t;

	// DUT ports
	logic                          clk;
	logic                          arst_n         = 1'b0;
	logic                          in_valid       = 1'b0;
	logic                          in_stall;
	logic [7:0]                    packet_byte    = 8'd0;
	logic                          last_byte      = 1'b0;
	logic                          out_valid;
	logic                          out_stall      = 1'b0;
	logic [1:0]                    verdict;
	logic [31:0]                   source_address;
	logic                          cfg_valid      = 1'b0;
	logic                          cfg_ready;
	logic [icr_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
	logic [15:0]                   cfg_data       = 16'd0;

	// Stimulus and scoreboard
	wire_byte_t      pending_bytes[$];
	classification_t expected_classes[$];
	int              bytes_queued   = 0;
	int              packets_queued = 0;
	int              mismatch_count = 0;
	int              send_idle_pct  = 0;
	int              recv_stall_pct = 0;
	bit              hold_armed     = 1'b0;
	logic            hold_output    = 1'b0;

	// Register copies as the block should hold them
	logic [15:0] ident_setting = 16'd0;
	logic [15:0] seq_setting   = 16'd1;

	// Parse state of the classifier model
	logic [icr_pkg::OFF_W-1:0] parse_pos     = '0;
	logic [5:0]                hdr_len       = '0;
	logic                      outer_icmp    = 1'b0;
	logic [7:0]                msg_type      = '0;
	logic [15:0]               outer_id      = '0;
	logic [15:0]               outer_seq     = '0;
	logic                      inner_icmp    = 1'b0;
	logic [5:0]                inner_hdr_len = '0;
	logic [15:0]               inner_id      = '0;
	logic [15:0]               inner_seq     = '0;
	logic [31:0]               src_addr      = '0;

	icmp_reply_classifier dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.packet_byte    (packet_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.verdict        (verdict),
		.source_address (source_address),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Advance the classifier model by one accepted byte; a final byte yields its verdict
	task automatic classify_byte(input logic [7:0] b, input logic last);
		int off, h, p, q, n;
		classification_t res;
		off = int'(parse_pos);
		if (off == 0) hdr_len = {b[3:0], 2'b00};
		h = int'(hdr_len);
		if (off == 9) outer_icmp = (b == icr_pkg::PROTO_ICMP);
		if (off >= 12 && off <= 15) src_addr[8*(15-off) +: 8] = b;
		// ICMP header, fields low byte first
		if (off == h) msg_type = b;
		if (off == h + 4) outer_id[7:0] = b;
		if (off == h + 5) outer_id[15:8] = b;
		if (off == h + 6) outer_seq[7:0] = b;
		if (off == h + 7) outer_seq[15:8] = b;
		// quoted inner header and its ICMP fields
		p = h + 8;
		if (off == p) inner_hdr_len = {b[3:0], 2'b00};
		if (off == p + 9) inner_icmp = (b == icr_pkg::PROTO_ICMP);
		if (off > p) begin
			q = p + int'(inner_hdr_len);
			if (off == q + 4) inner_id[7:0] = b;
			if (off == q + 5) inner_id[15:8] = b;
			if (off == q + 6) inner_seq[7:0] = b;
			if (off == q + 7) inner_seq[15:8] = b;
		end
		if (last) begin
			n = (off + 1 > icr_pkg::RECV_LIMIT) ? icr_pkg::RECV_LIMIT : off + 1;
			res.verdict = icr_pkg::VERDICT_IGNORED;
			if (outer_icmp && n >= h + 8) begin
				if (msg_type == icr_pkg::TYPE_ECHO_REPLY && outer_seq == seq_setting &&
						outer_id == ident_setting) begin
					res.verdict = icr_pkg::VERDICT_ECHO_REPLY;
				end else if (msg_type == icr_pkg::TYPE_TIME_EXCEEDED && inner_icmp &&
						n >= h + 16 + int'(inner_hdr_len) &&
						inner_seq == seq_setting && inner_id == ident_setting) begin
					res.verdict = icr_pkg::VERDICT_TIME_EXCEEDED;
				end
			end
			res.source = src_addr;
			expected_classes.push_back(res);
			parse_pos = '0;
			hdr_len = '0;
			outer_icmp = 1'b0;
			msg_type = '0;
			outer_id = '0;
			outer_seq = '0;
			inner_icmp = 1'b0;
			inner_hdr_len = '0;
			inner_id = '0;
			inner_seq = '0;
			src_addr = '0;
		end else if (off < icr_pkg::OFF_LAST) begin
			parse_pos = parse_pos + 1'b1;
		end
	endtask

	// Byte driver: holds a stalled item, otherwise offers the next one or idles
	always @(posedge clk) begin : byte_driver
		wire_byte_t staged;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				classify_byte(packet_byte, last_byte);
			end
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					staged = pending_bytes.pop_front();
					in_valid <= 1'b1;
					packet_byte <= staged.data;
					last_byte <= staged.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stall
	always @(posedge clk) begin : result_monitor
		classification_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_classes.size() == 0) begin
					$display("%0t: result with none expected: verdict %0d source %h",
						$time, verdict, source_address);
					mismatch_count++;
				end else begin
					want = expected_classes.pop_front();
					if (verdict !== want.verdict) begin
						$display("%0t: verdict mismatch: expected %0d, actual %0d",
							$time, want.verdict, verdict);
						mismatch_count++;
					end
					if (source_address !== want.source) begin
						$display("%0t: source mismatch: expected %h, actual %h",
							$time, want.source, source_address);
						mismatch_count++;
					end
				end
			end
			out_stall <= hold_output || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Long receiver hold-off so the block backs up into its input
	initial begin
		wait (hold_armed);
		@(posedge clk);
		hold_output <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_output <= 1'b0;
	end

	task automatic write_reg(input logic [icr_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] val);
		logic granted;
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			granted = cfg_ready;
			@(posedge clk);
		end while (!granted);
		cfg_valid <= 1'b0;
		if (idx == icr_pkg::REG_OWN_IDENTIFIER) ident_setting = val;
		else if (idx == icr_pkg::REG_EXPECTED_SEQUENCE) seq_setting = val;
	endtask

	// Wait until all bytes are taken and all verdicts are back, then let the pipe settle
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_classes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Build one packet of len random bytes with the header fields laid over it;
	// outer ICMP fields go last so they win where the layouts overlap
	task automatic queue_probe_reply(input int len, input logic [3:0] ihl,
			input logic [7:0] proto, input logic [7:0] mtype,
			input logic [15:0] id, input logic [15:0] seq, input logic [3:0] ihl2,
			input logic [7:0] proto2, input logic [15:0] id2, input logic [15:0] seq2);
		logic [7:0] pkt[];
		int at[13];
		logic [7:0] val[13];
		int h, p, q;
		h = int'(ihl) * 4;
		p = h + 8;
		q = p + int'(ihl2) * 4;
		pkt = new[len];
		foreach (pkt[i]) pkt[i] = 8'($urandom);
		at = '{0, 9, p, p + 9, q + 4, q + 5, q + 6, q + 7, h, h + 4, h + 5, h + 6, h + 7};
		val = '{{4'($urandom), ihl}, proto, {4'h4, ihl2}, proto2, id2[7:0], id2[15:8],
			seq2[7:0], seq2[15:8], mtype, id[7:0], id[15:8], seq[7:0], seq[15:8]};
		foreach (at[i]) begin
			if (at[i] < len) pkt[at[i]] = val[i];
		end
		foreach (pkt[i]) pending_bytes.push_back('{pkt[i], i == len - 1});
		bytes_queued += len;
		packets_queued++;
	endtask

	// Mostly the programmed value, sometimes one bit off or random
	function automatic logic [15:0] near_value(input logic [15:0] v);
		int r;
		r = $urandom_range(19);
		if (r < 14) return v;
		if (r < 17) return v ^ (16'd1 << $urandom_range(15));
		return 16'($urandom);
	endfunction

	task automatic queue_random_packet();
		int kind, len, full;
		logic [3:0] ihl, ihl2;
		logic [7:0] proto, proto2, mtype;
		kind = $urandom_range(99);
		ihl = ($urandom_range(7) == 0) ? 4'($urandom) : 4'd5;
		ihl2 = ($urandom_range(7) == 0) ? 4'($urandom) : 4'd5;
		proto = ($urandom_range(15) == 0) ? 8'($urandom) : icr_pkg::PROTO_ICMP;
		proto2 = ($urandom_range(15) == 0) ? 8'($urandom) : icr_pkg::PROTO_ICMP;
		mtype = ($urandom_range(1) == 0) ? icr_pkg::TYPE_ECHO_REPLY :
			icr_pkg::TYPE_TIME_EXCEEDED;
		if (mtype == icr_pkg::TYPE_ECHO_REPLY) full = int'(ihl) * 4 + 8 + $urandom_range(24);
		else full = int'(ihl) * 4 + int'(ihl2) * 4 + 16 + $urandom_range(12);
		len = full;
		// noise, then truncated, then well-formed
		if (kind >= 90) begin
			mtype = 8'($urandom);
			len = $urandom_range(1, 64);
		end else if (kind >= 78) begin
			len = $urandom_range(1, full);
		end
		queue_probe_reply(len, ihl, proto, mtype, near_value(ident_setting),
			near_value(seq_setting), ihl2, proto2, near_value(ident_setting),
			near_value(seq_setting));
	endtask

	task automatic run_random_phase(input int send_pct, input int recv_pct,
			input int nbytes, input int npackets);
		int b0, p0;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		b0 = bytes_queued;
		p0 = packets_queued;
		while (bytes_queued - b0 < nbytes || packets_queued - p0 < npackets) begin
			queue_random_packet();
		end
		wait_idle();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed packets against the reset register values
		queue_probe_reply(28, 4'd5, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_ECHO_REPLY,
			16'd0, 16'd1, 4'd5, icr_pkg::PROTO_ICMP, 16'd0, 16'd0);
		queue_probe_reply(60, 4'd5, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_TIME_EXCEEDED,
			16'h1234, 16'h5678, 4'd5, icr_pkg::PROTO_ICMP, 16'd0, 16'd1);
		queue_probe_reply(28, 4'd5, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_ECHO_REPLY,
			16'd0, 16'd2, 4'd5, icr_pkg::PROTO_ICMP, 16'd0, 16'd1);
		queue_probe_reply(28, 4'd5, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_ECHO_REPLY,
			16'h0100, 16'd1, 4'd5, icr_pkg::PROTO_ICMP, 16'd0, 16'd1);
		queue_probe_reply(28, 4'd5, PROTO_TCP, icr_pkg::TYPE_ECHO_REPLY,
			16'd0, 16'd1, 4'd5, icr_pkg::PROTO_ICMP, 16'd0, 16'd1);
		queue_probe_reply(56, 4'd5, icr_pkg::PROTO_ICMP, TYPE_UNREACHABLE,
			16'd0, 16'd1, 4'd5, icr_pkg::PROTO_ICMP, 16'd0, 16'd1);
		queue_probe_reply(1, 4'd5, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_ECHO_REPLY,
			16'd0, 16'd1, 4'd5, icr_pkg::PROTO_ICMP, 16'd0, 16'd1);
		// one byte short of a full echo header and of a full quoted header
		queue_probe_reply(27, 4'd5, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_ECHO_REPLY,
			16'd0, 16'd1, 4'd5, icr_pkg::PROTO_ICMP, 16'd0, 16'd1);
		queue_probe_reply(55, 4'd5, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_TIME_EXCEEDED,
			16'd7, 16'd9, 4'd5, icr_pkg::PROTO_ICMP, 16'd0, 16'd1);
		queue_probe_reply(56, 4'd5, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_TIME_EXCEEDED,
			16'd7, 16'd9, 4'd5, PROTO_UDP, 16'd0, 16'd1);
		queue_probe_reply(56, 4'd5, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_TIME_EXCEEDED,
			16'd0, 16'd1, 4'd5, icr_pkg::PROTO_ICMP, 16'h0080, 16'd1);
		// header length zero and fifteen, quoted header length zero
		queue_probe_reply(16, 4'd0, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_ECHO_REPLY,
			16'd0, 16'd1, 4'd5, icr_pkg::PROTO_ICMP, 16'd0, 16'd1);
		queue_probe_reply(68, 4'd15, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_ECHO_REPLY,
			16'd0, 16'd1, 4'd5, icr_pkg::PROTO_ICMP, 16'd0, 16'd1);
		queue_probe_reply(36, 4'd5, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_TIME_EXCEEDED,
			16'd3, 16'd4, 4'd0, icr_pkg::PROTO_ICMP, 16'd0, 16'd1);
		// source bytes partly missing
		queue_probe_reply(14, 4'd1, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_ECHO_REPLY,
			16'd0, 16'd1, 4'd5, icr_pkg::PROTO_ICMP, 16'd0, 16'd1);
		wait_idle();

		// Top extremes, plus writes to unused indexes
		write_reg(icr_pkg::REG_OWN_IDENTIFIER, 16'hFFFF);
		write_reg(icr_pkg::REG_EXPECTED_SEQUENCE, 16'hFFFF);
		write_reg(8'hFF, 16'h0000);
		write_reg(8'h02, 16'h5A5A);
		queue_probe_reply(28, 4'd5, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_ECHO_REPLY,
			16'hFFFF, 16'hFFFF, 4'd5, icr_pkg::PROTO_ICMP, 16'd0, 16'd0);
		queue_probe_reply(56, 4'd5, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_TIME_EXCEEDED,
			16'd0, 16'd0, 4'd5, icr_pkg::PROTO_ICMP, 16'hFFFF, 16'hFFFF);
		queue_probe_reply(28, 4'd5, icr_pkg::PROTO_ICMP, icr_pkg::TYPE_ECHO_REPLY,
			16'hFFFF, 16'h7FFF, 4'd5, icr_pkg::PROTO_ICMP, 16'd0, 16'd0);
		run_random_phase(0, 0, 120, 2);

		// Bottom extremes, sender mostly idle
		write_reg(icr_pkg::REG_OWN_IDENTIFIER, 16'h0000);
		write_reg(icr_pkg::REG_EXPECTED_SEQUENCE, 16'h0000);
		write_reg(8'($urandom_range(2, 254)), 16'($urandom));
		run_random_phase(81, 0, 120, 2);

		// Random settings, receiver mostly stalled
		write_reg(icr_pkg::REG_OWN_IDENTIFIER, 16'($urandom));
		write_reg(icr_pkg::REG_EXPECTED_SEQUENCE, 16'($urandom));
		run_random_phase(0, 81, 120, 2);

		// Random settings, light idling on both sides
		write_reg(icr_pkg::REG_EXPECTED_SEQUENCE, 16'($urandom));
		write_reg(icr_pkg::REG_OWN_IDENTIFIER, 16'($urandom));
		run_random_phase(7, 7, 120, 2);

		// Short packets back to back while the receiver holds off
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_armed = 1'b1;
		repeat (20) begin
			queue_probe_reply($urandom_range(1, 12), 4'($urandom_range(2)),
				icr_pkg::PROTO_ICMP, icr_pkg::TYPE_ECHO_REPLY, ident_setting, seq_setting,
				4'd5, icr_pkg::PROTO_ICMP, ident_setting, seq_setting);
		end
		wait_idle();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("icmp_reply_classifier_test: PASS");
		end else begin
			$display("icmp_reply_classifier_test: FAIL");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("icmp_reply_classifier_test: FAIL");
		$finish;
	end

endmodule
